[sv/nses_pkg.sv]
// shared constants and types for the nearest sorted entry search block
`timescale 1ns / 1ps
package nses_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int POS_W      = 32;
   localparam int ENTRY_W    = 11;
   localparam int QLIMIT_W   = 32;
   localparam int QCOUNT_W   = 33;
   localparam int OUT_IDX_W  = 10;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BUDGET = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HALTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LIMIT = 2'd2;

   // command from the control path to the search engine
   typedef struct packed {
      logic             load;
      logic             search;
      logic [POS_W-1:0] position;
   } nses_cmd_type;

endpackage

[sv/nses_if.sv]
// request and response channel interfaces for the nearest sorted entry search block
`timescale 1ns / 1ps
interface nses_req_if;
   import nses_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [POS_W-1:0] position;

   modport source (output valid, action, position, input ready);
   modport sink (input valid, action, position, output ready);
endinterface

interface nses_rsp_if;
   import nses_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] nearest_index;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, nearest_index, status, input ready);
   modport sink (input valid, nearest_index, status, output ready);
endinterface

[sv/nses_engine.sv]
// position table memory and the bisection sequencer with its shared distance unit
`timescale 1ns / 1ps
module nses_engine #(
   parameter int TABLE_DEPTH = nses_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nses_pkg::nses_cmd_type cmd,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [CNT_W-1:0]       span,
   output logic                   done,
   output logic [IDX_W-1:0]       done_index
);
   import nses_pkg::*;

   typedef enum logic [1:0] {E_IDLE, E_STEP, E_HI, E_LO} eng_state_type;

   logic [POS_W-1:0] table_mem [TABLE_DEPTH];

   eng_state_type    state_ff;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] n_ff;
   logic [IDX_W-1:0] probe_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [POS_W-1:0] x_ff;
   logic [POS_W-1:0] rd_data_ff;
   logic [POS_W-1:0] diff_ff;
   logic             done_ff;
   logic [IDX_W-1:0] done_index_ff;

   logic [CNT_W-1:0] half;
   logic             below;
   logic [CNT_W-1:0] lo_in;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] probe_in;
   logic [CNT_W-1:0] n_last;
   logic [POS_W-1:0] delta;
   logic [IDX_W-1:0] rd_addr;

   // one bisection step per cycle on the word read last cycle
   assign half     = cnt_ff >> 1;
   assign below    = rd_data_ff < x_ff;
   assign lo_in    = below ? (CNT_W'(probe_ff) + CNT_W'(1)) : lo_ff;
   assign cnt_in   = below ? (cnt_ff - half - CNT_W'(1)) : half;
   assign probe_in = lo_in + (cnt_in >> 1);
   assign n_last   = n_ff - CNT_W'(1);

   // shared distance unit for both neighbors
   assign delta = (rd_data_ff >= x_ff) ? (rd_data_ff - x_ff) : (x_ff - rd_data_ff);

   always_comb begin
      unique case (state_ff)
         E_IDLE: rd_addr = IDX_W'(span >> 1);
         E_STEP: begin
            if (cnt_in != '0) begin
               rd_addr = probe_in[IDX_W-1:0];
            end else begin
               rd_addr = lo_in[IDX_W-1:0];
            end
         end
         E_HI:    rd_addr = pos_ff - IDX_W'(1);
         E_LO:    rd_addr = pos_ff;
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         table_mem[wr_addr] <= cmd.position;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            E_IDLE: begin
               if (cmd.search) begin
                  x_ff     <= cmd.position;
                  n_ff     <= span;
                  lo_ff    <= '0;
                  cnt_ff   <= span;
                  probe_ff <= IDX_W'(span >> 1);
                  state_ff <= E_STEP;
               end
            end
            E_STEP: begin
               lo_ff    <= lo_in;
               cnt_ff   <= cnt_in;
               probe_ff <= probe_in[IDX_W-1:0];
               if (cnt_in == '0) begin
                  if (lo_in == n_ff) begin
                     done_ff       <= 1'b1;
                     done_index_ff <= n_last[IDX_W-1:0];
                     state_ff      <= E_IDLE;
                  end else if (lo_in == '0) begin
                     done_ff       <= 1'b1;
                     done_index_ff <= '0;
                     state_ff      <= E_IDLE;
                  end else begin
                     pos_ff   <= lo_in[IDX_W-1:0];
                     state_ff <= E_HI;
                  end
               end
            end
            E_HI: begin
               diff_ff  <= delta;
               state_ff <= E_LO;
            end
            E_LO: begin
               done_ff       <= 1'b1;
               done_index_ff <= (diff_ff < delta) ? pos_ff : (pos_ff - IDX_W'(1));
               state_ff      <= E_IDLE;
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

   assign done       = done_ff;
   assign done_index = done_index_ff;

   a_step_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_STEP) |-> (cnt_ff != '0))
      else $error("bisection step with empty range");

   a_probe_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_STEP) |-> (CNT_W'(probe_ff) < n_ff))
      else $error("probe outside search span");

   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != E_IDLE) |-> !cmd.search)
      else $error("search started while engine busy");

endmodule

[sv/nearest_sorted_entry_search.sv]
// top level of the nearest sorted entry search block: control, budget, config and response
//
// req_bus carries one word per item: action 0 appends position to the table at the next
// free index, action 1 asks for the index of the table entry nearest to position.
// rsp_bus returns exactly one word per item: nearest_index and status (ok, out of range,
// budget exceeded, halted, table full). Both use valid/ready; a word moves when both are high.
// csr_we/csr_index/csr_wdata write line_length (0), entry_count (1), query_limit (2); other
// indexes are dropped. Write them only while no item is in flight.
// A load or any error answer passes through S_DELIVER after acceptance and shows on rsp_bus
// once the output register is free. A query does one bisection probe per cycle through the
// single table read port, two more reads for the neighbor compare, then hand-off. One item
// is in flight at a time; req_bus.ready is high only while idle, already in the cycle in which
// a word shows, and an item can be accepted while the previous word still waits.
// A stalled rsp_bus holds its word; the next finished word waits internally until it frees.
// Reset clears the load and query counts and the halt flag, and restores the registers to
// their defaults. Table contents are not cleared; unloaded entries must not be searched.
`timescale 1ns / 1ps
module nearest_sorted_entry_search #(
   parameter int TABLE_DEPTH = nses_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   nses_req_if.sink                         req_bus,
   nses_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [nses_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nses_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nses_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SPAN_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_DELIVER} ctl_state_type;

   ctl_state_type        state_ff;
   logic [POS_W-1:0]     line_length_ff;
   logic [ENTRY_W-1:0]   entry_count_ff;
   logic [QLIMIT_W-1:0]  query_limit_ff;
   logic                 halted_ff;
   logic [CNT_W-1:0]     load_count_ff;
   logic [QCOUNT_W-1:0]  query_count_ff;
   logic [OUT_IDX_W-1:0] res_index_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 rsp_valid_ff;
   logic [OUT_IDX_W-1:0] rsp_index_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic                 accept;
   logic                 full;
   logic                 out_range;
   logic                 over_budget;
   logic                 out_free;
   logic [QCOUNT_W-1:0]  query_count_in;
   logic [SPAN_W-1:0]    ec_wide;
   logic [SPAN_W-1:0]    span_wide;
   logic [CNT_W-1:0]     span;
   nses_cmd_type         cmd;
   logic                 eng_done;
   logic [IDX_W-1:0]     eng_index;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign full           = (load_count_ff == CNT_W'(TABLE_DEPTH));
   assign out_range      = (req_bus.position > line_length_ff);
   assign query_count_in = query_count_ff + QCOUNT_W'(1);
   assign over_budget    = (query_count_in > {1'b0, query_limit_ff});

   // search span clamped to 1 .. table depth
   assign ec_wide = SPAN_W'(entry_count_ff);
   always_comb begin
      if (ec_wide == '0) begin
         span_wide = SPAN_W'(1);
      end else if (ec_wide > SPAN_W'(TABLE_DEPTH)) begin
         span_wide = SPAN_W'(TABLE_DEPTH);
      end else begin
         span_wide = ec_wide;
      end
   end
   assign span = span_wide[CNT_W-1:0];

   assign cmd.load     = accept && !halted_ff && (req_bus.action == ACT_LOAD) && !full;
   assign cmd.search   = accept && !halted_ff && (req_bus.action == ACT_QUERY) &&
                         !out_range && !over_budget;
   assign cmd.position = req_bus.position;

   nses_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_addr    (load_count_ff[IDX_W-1:0]),
      .span       (span),
      .done       (eng_done),
      .done_index (eng_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '1;
         entry_count_ff <= ENTRY_W'(1);
         query_limit_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_LENGTH: line_length_ff <= csr_wdata[POS_W-1:0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[ENTRY_W-1:0];
            CSR_QUERY_LIMIT: query_limit_ff <= csr_wdata[QLIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         halted_ff      <= 1'b0;
         load_count_ff  <= '0;
         query_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_index_ff  <= '0;
                  res_status_ff <= ST_OK;
                  state_ff      <= S_DELIVER;
                  if (halted_ff) begin
                     res_status_ff <= ST_HALTED;
                  end else if (req_bus.action == ACT_LOAD) begin
                     if (full) begin
                        res_status_ff <= ST_FULL;
                     end else begin
                        res_index_ff  <= OUT_IDX_W'(load_count_ff);
                        load_count_ff <= load_count_ff + CNT_W'(1);
                     end
                  end else if (out_range) begin
                     res_status_ff <= ST_RANGE;
                     halted_ff     <= 1'b1;
                  end else begin
                     query_count_ff <= query_count_in;
                     if (over_budget) begin
                        res_status_ff <= ST_BUDGET;
                        halted_ff     <= 1'b1;
                     end else begin
                        state_ff <= S_SEARCH;
                     end
                  end
               end
            end
            S_SEARCH: begin
               if (eng_done) begin
                  res_index_ff  <= OUT_IDX_W'(eng_index);
                  res_status_ff <= ST_OK;
                  state_ff      <= S_DELIVER;
               end
            end
            S_DELIVER: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_index_ff  <= res_index_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.nearest_index = rsp_index_ff;
   assign rsp_bus.status        = rsp_status_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_load_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("load count past table depth");

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (state_ff == S_SEARCH))
      else $error("engine finished outside a search");

   a_halted_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && halted_ff) |=> ((load_count_ff == $past(load_count_ff)) &&
                                 (query_count_ff == $past(query_count_ff))))
      else $error("halted block changed its counts");

endmodule

[tb/tb_nearest_sorted_entry_search.sv]
// self-checking testbench for the nearest sorted entry search block
`timescale 1ns / 1ps
module tb_nearest_sorted_entry_search;
   import nses_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] near_idx;
      logic [STATUS_W-1:0]  status;
   } nearest_answer_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nses_req_if req_bus ();
   nses_rsp_if rsp_bus ();

   nearest_sorted_entry_search #(
      .TABLE_DEPTH (DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [POS_W-1:0]    pos_table [DEPTH];
   int unsigned         loaded = 0;
   longint unsigned     queries = 0;
   bit                  halted = 1'b0;
   logic [POS_W-1:0]    line_len = '1;
   logic [ENTRY_W-1:0]  entry_cnt = 11'd1;
   logic [QLIMIT_W-1:0] q_limit = '1;
   logic [POS_W-1:0]    sorted_tail = '0;

   nearest_answer_type answers_due [$];
   int  error_count = 0;
   int  rsp_count = 0;
   int  rsp_hold_request = 0;
   int  rsp_hold_left = 0;
   bit  steady_flow = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < 40) $display("mismatch at word %0d: %s", rsp_count, msg);
      error_count++;
   endtask

   function automatic int unsigned search_span();
      if (entry_cnt == 0) return 1;
      if (entry_cnt > DEPTH) return DEPTH;
      return entry_cnt;
   endfunction

   function automatic nearest_answer_type predict_answer(input logic act,
                                                         input logic [POS_W-1:0] x);
      nearest_answer_type ans;
      int unsigned span, lo, remaining, half, probe, pick;
      logic [POS_W-1:0] d_here, d_prev;
      ans.near_idx = '0;
      ans.status = ST_OK;
      if (halted) begin
         ans.status = ST_HALTED;
      end else if (act == ACT_LOAD) begin
         if (loaded >= DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            pos_table[loaded] = x;
            ans.near_idx = loaded[OUT_IDX_W-1:0];
            loaded++;
         end
      end else if (x > line_len) begin
         ans.status = ST_RANGE;
         halted = 1'b1;
      end else begin
         queries++;
         if (queries > q_limit) begin
            ans.status = ST_BUDGET;
            halted = 1'b1;
         end else begin
            span = search_span();
            lo = 0;
            remaining = span;
            while (remaining > 0) begin
               half = remaining / 2;
               probe = lo + half;
               if (pos_table[probe] < x) begin
                  lo = probe + 1;
                  remaining = remaining - half - 1;
               end else begin
                  remaining = half;
               end
            end
            if (lo == span) begin
               pick = span - 1;
            end else if (lo == 0) begin
               pick = 0;
            end else begin
               d_here = (pos_table[lo] >= x) ? pos_table[lo] - x : x - pos_table[lo];
               d_prev = (pos_table[lo-1] >= x) ? pos_table[lo-1] - x : x - pos_table[lo-1];
               pick = (d_here < d_prev) ? lo : lo - 1;
            end
            ans.near_idx = pick[OUT_IDX_W-1:0];
         end
      end
      return ans;
   endfunction

   function automatic logic [POS_W-1:0] next_load_position();
      logic [63:0] stride, sum;
      logic [POS_W-1:0] noise;
      if ($urandom_range(0, 99) < 12) begin
         noise = $urandom;
         return noise;
      end
      case ($urandom_range(0, 2))
         0: stride = $urandom_range(0, 3);
         1: stride = $urandom_range(0, 1000);
         default: stride = $urandom_range(0, 1 << 22);
      endcase
      sum = {32'b0, sorted_tail} + stride;
      sorted_tail = (sum > {32'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
      return sorted_tail;
   endfunction

   function automatic logic [POS_W-1:0] pick_query_position();
      int unsigned span, k;
      logic [63:0] v;
      span = search_span();
      k = $urandom_range(0, span - 1);
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: begin
            v = {32'b0, pos_table[k]} + $urandom_range(0, 8);
            v = (v >= 4) ? v - 4 : 64'd0;
         end
         2: begin
            if (k + 1 < span)
               v = ({32'b0, pos_table[k]} + {32'b0, pos_table[k+1]} + $urandom_range(0, 1)) >> 1;
            else
               v = pos_table[k];
         end
         3: v = $urandom_range(0, 1) ? {32'b0, line_len} : 64'd0;
         default: v = pos_table[k];
      endcase
      if (v > {32'b0, line_len}) v = v % ({32'b0, line_len} + 64'd1);
      return v[POS_W-1:0];
   endfunction

   task automatic send_word(input logic act, input logic [POS_W-1:0] pos);
      while (!steady_flow && $urandom_range(0, 99) < 23) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.position <= pos;
      answers_due.push_back(predict_answer(act, pos));
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic wait_all_answers();
      req_bus.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LINE_LENGTH: line_len = data;
         CSR_ENTRY_COUNT: entry_cnt = data[ENTRY_W-1:0];
         CSR_QUERY_LIMIT: q_limit = data;
         default: ;
      endcase
   endtask

   // receiver side
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            rsp_hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 23);
         end
      end
   end

   always @(posedge clock) begin
      nearest_answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word idx %0d status %0d",
                                      rsp_bus.nearest_index, rsp_bus.status));
         end else begin
            want = answers_due.pop_front();
            if (rsp_bus.nearest_index !== want.near_idx)
               report_mismatch($sformatf("nearest_index %0d, want %0d",
                                         rsp_bus.nearest_index, want.near_idx));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_bus.status, want.status));
         end
         rsp_count++;
      end
   end

   task automatic test_reset_defaults();
      send_word(ACT_LOAD, 32'd0);
      send_word(ACT_LOAD, 32'd100);
      send_word(ACT_LOAD, 32'd200);
      send_word(ACT_QUERY, POS_MAX);
      send_word(ACT_QUERY, 32'd50);
      send_word(ACT_QUERY, 32'd0);
   endtask

   task automatic test_directed_search();
      send_word(ACT_LOAD, 32'd200);
      send_word(ACT_LOAD, 32'd1000);
      send_word(ACT_LOAD, 32'd1001);
      send_word(ACT_LOAD, 32'd50000);
      send_word(ACT_LOAD, 32'd1000000);
      wait_all_answers();
      csr_write(CSR_ENTRY_COUNT, 32'd8);
      send_word(ACT_QUERY, 32'd0);
      send_word(ACT_QUERY, 32'd50);
      send_word(ACT_QUERY, 32'd51);
      send_word(ACT_QUERY, 32'd150);
      send_word(ACT_QUERY, 32'd200);
      send_word(ACT_QUERY, 32'd600);
      send_word(ACT_QUERY, 32'd25000);
      send_word(ACT_QUERY, 32'd1000000);
      send_word(ACT_QUERY, POS_MAX);
      wait_all_answers();
      csr_write(CSR_ENTRY_COUNT, 32'd0);
      send_word(ACT_QUERY, POS_MAX);
      wait_all_answers();
      csr_write(CSR_LINE_LENGTH, 32'd0);
      send_word(ACT_QUERY, 32'd0);
      wait_all_answers();
      csr_write(CSR_LINE_LENGTH, POS_MAX);
      csr_write(CSR_QUERY_LIMIT, POS_MAX);
      csr_write(CSR_ENTRY_COUNT, 32'd8);
      csr_write(CSR_UNUSED, 32'd0);
      send_word(ACT_QUERY, POS_MAX);
   endtask

   task automatic test_random_traffic(input int n_items);
      int sent, burst, phase;
      logic [CSR_DATA_W-1:0] setting;
      sent = 0;
      phase = 0;
      sorted_tail = 32'd1000000;
      while (sent < n_items) begin
         wait_all_answers();
         case ($urandom_range(0, 3))
            0: setting = 1;
            1: setting = loaded;
            2: setting = $urandom_range(loaded, 1);
            default: setting = $urandom_range((loaded < 16) ? loaded : 16, 1);
         endcase
         csr_write(CSR_ENTRY_COUNT, setting);
         case ($urandom_range(0, 3))
            0, 1: setting = POS_MAX;
            2: setting = $urandom;
            default: setting = $urandom_range(5000, 0);
         endcase
         csr_write(CSR_LINE_LENGTH, setting);
         if ($urandom_range(0, 3) == 0)
            csr_write(CSR_QUERY_LIMIT, $urandom_range(32'hFFFF_FFFF, 32'h0001_0000));
         steady_flow = (phase == 2);
         burst = $urandom_range(20, 60);
         for (int i = 0; i < burst && sent < n_items; i++) begin
            if (loaded < 1000 && $urandom_range(0, 1) == 0)
               send_word(ACT_LOAD, next_load_position());
            else
               send_word(ACT_QUERY, pick_query_position());
            sent++;
         end
         phase++;
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_all_answers();
      rsp_hold_request = 200;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 0 && loaded < 1000)
            send_word(ACT_LOAD, next_load_position());
         else
            send_word(ACT_QUERY, pick_query_position());
      end
      wait_all_answers();
   endtask

   task automatic test_table_full();
      wait_all_answers();
      while (loaded < DEPTH - 1) send_word(ACT_LOAD, next_load_position());
      send_word(ACT_LOAD, POS_MAX);
      for (int i = 0; i < 3; i++) send_word(ACT_LOAD, $urandom);
      wait_all_answers();
      csr_write(CSR_ENTRY_COUNT, DEPTH);
      csr_write(CSR_LINE_LENGTH, POS_MAX);
      send_word(ACT_QUERY, 32'd0);
      send_word(ACT_QUERY, POS_MAX);
      for (int i = 0; i < 10; i++) send_word(ACT_QUERY, pick_query_position());
      wait_all_answers();
      csr_write(CSR_ENTRY_COUNT, 32'h7FF);
      send_word(ACT_QUERY, POS_MAX);
      for (int i = 0; i < 10; i++) send_word(ACT_QUERY, pick_query_position());
   endtask

   task automatic test_sticky_halt();
      logic [POS_W-1:0] limit_val;
      wait_all_answers();
      if ($urandom_range(0, 1) == 1) begin
         limit_val = $urandom_range(0, 1) ? 32'd0 : $urandom_range(32'hFFFF_FFFE, 0);
         csr_write(CSR_LINE_LENGTH, limit_val);
         send_word(ACT_QUERY, $urandom_range(32'hFFFF_FFFF, limit_val + 1));
      end else begin
         csr_write(CSR_QUERY_LIMIT, $urandom_range(0, 1) ? 32'd0 : queries[31:0]);
         send_word(ACT_QUERY, $urandom);
      end
      send_word(ACT_LOAD, $urandom);
      send_word(ACT_QUERY, 32'd0);
      send_word(ACT_QUERY, POS_MAX);
      send_word(ACT_LOAD, 32'd0);
      send_word(ACT_QUERY, $urandom);
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_LINE_LENGTH;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_LOAD;
      req_bus.position <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_search();
      test_random_traffic(300);
      test_backpressure();
      test_table_full();
      test_sticky_halt();
      wait_all_answers();
      repeat (30) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", answers_due.size()));
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
